// ----- hdl/ffe_pkg.sv -----
// Shared definitions for the fire effect frame engine.
// Default geometry, colour ramp constant and the controller/datapath command and status types.
// No dependencies.
package ffe_pkg;

	// default geometry of the heat frame and the display window
	localparam int FRAME_WIDTH_DEF    = 320;
	localparam int FRAME_ROWS_DEF     = 50;
	localparam int HOT_ROW_DEF        = 46;
	localparam int VIEW_FIRST_ROW_DEF = 5;
	localparam int VIEW_ROWS_DEF      = 25;

	// heat cell, output and coordinate widths
	localparam int HEAT_W  = 8;
	localparam int PIXEL_W = 16;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 9;

	// number of palette entries above the base colour in the fire ramp
	localparam logic [HEAT_W-1:0] COLOUR_SPAN = 8'd15;

	// commands from the controller to the datapath
	typedef struct packed {
		logic clear_wr;   // write zero at the sweep counter
		logic cnt_clr;    // reset the sweep counter
		logic cnt_inc;    // advance the sweep counter
		logic sweep_rd;   // read the frame at the sweep counter
		logic load_in;    // capture row and column of a request
		logic row_sub;    // fold the row into the view window
		logic col_sub;    // fold the column into the frame width
		logic addr_load;  // form the linear read address
		logic addr_sub;   // fold the address into the frame size
		logic px_rd;      // read the frame at the pixel address
		logic res_pix;    // capture the colour index as the result
		logic res_zero;   // capture zero as the result
		logic out_load;   // move the result into the output register
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic cnt_clear_last; // counter at the last frame cell
		logic cnt_end;        // counter one past the last frame cell
		logic pipe_busy;      // stencil pipeline still holds work
		logic row_ge;         // row outside the view window
		logic col_ge;         // column outside the frame width
		logic addr_ge;        // address outside the frame
		logic out_free;       // output register can take a result
	} sts_t;

endpackage

// ----- hdl/ffe_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Used for the heat frame store; no dependencies.
module ffe_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [0:DEPTH-1];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/ffe_dpath.sv -----
// Datapath of the fire effect frame engine: heat frame RAM, sweep counter, stencil window,
// decay stage, pixel address folding, colour mapping and the output register.
// Depends on ffe_pkg and ffe_ram.
module ffe_dpath #(
	parameter int FRAME_WIDTH    = ffe_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_ROWS     = ffe_pkg::FRAME_ROWS_DEF,
	parameter int HOT_ROW        = ffe_pkg::HOT_ROW_DEF,
	parameter int VIEW_FIRST_ROW = ffe_pkg::VIEW_FIRST_ROW_DEF,
	parameter int VIEW_ROWS      = ffe_pkg::VIEW_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ffe_pkg::cmd_t                cmd,
	output ffe_pkg::sts_t                st,
	input  logic [ffe_pkg::ROW_W-1:0]    view_row,
	input  logic [ffe_pkg::COL_W-1:0]    view_col,
	input  logic                         cfg_wen,
	input  logic [ffe_pkg::HEAT_W-1:0]   cfg_wdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ffe_pkg::PIXEL_W-1:0]  m_tdata
);

	localparam int FS      = FRAME_WIDTH * FRAME_ROWS;
	localparam int AW      = $clog2(FS);
	localparam int CNT_W   = $clog2(FS + 1);
	localparam int SR_N    = 2 * FRAME_WIDTH + 3;
	// sweep address at which the first written stencil position is complete
	localparam int A_FIRST = 2 * FRAME_WIDTH + 1;
	// sweep address of the first stencil position in the hot rows
	localparam int A_HOT   = HOT_ROW * FRAME_WIDTH + FRAME_WIDTH + 1;
	localparam int ADDR_LIM = (VIEW_FIRST_ROW + VIEW_ROWS) * FRAME_WIDTH;
	localparam int AQ_W    = $clog2(ADDR_LIM + 1);
	localparam int HW      = ffe_pkg::HEAT_W;

	// sweep counter and stencil pipeline
	logic [CNT_W-1:0] cnt_q;
	logic             v_s1, v_s2;
	logic [CNT_W-1:0] a_s1, a_s2;
	logic [HW-1:0]    sr_q [0:SR_N-1];
	logic             wr_v_s3;
	logic [AW-1:0]    wr_addr_s3;
	logic [HW-1:0]    wr_data_s3;

	// pixel path
	logic [ffe_pkg::ROW_W-1:0] row_q;
	logic [ffe_pkg::COL_W-1:0] col_q;
	logic [AQ_W-1:0]           addr_q;
	logic [HW-1:0]             base_q;
	logic [ffe_pkg::PIXEL_W-1:0] res_q;
	logic                        out_v_q;
	logic [ffe_pkg::PIXEL_W-1:0] out_d_q;

	// RAM ports
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr, sweep_raddr;
	logic [HW-1:0] ram_wdata, ram_rdata;

	// stencil arithmetic
	logic [HW+2:0] sum;
	logic [HW-1:0] avg, dec_val;
	logic          hot, do_dec, edge_zero;

	// colour mapping
	logic [HW-1:0] lo, top, colour;

	ffe_ram #(
		.DATA_W (HW),
		.DEPTH  (FS)
	) u_heat (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// park the extra sweep read one past the frame at address zero
	assign sweep_raddr = (cnt_q == CNT_W'(FS)) ? '0 : AW'(cnt_q);

	// select RAM write and read sources
	always_comb begin
		if (cmd.clear_wr) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(cnt_q);
			ram_wdata = '0;
		end else begin
			ram_we    = wr_v_s3;
			ram_waddr = wr_addr_s3;
			ram_wdata = wr_data_s3;
		end
		ram_re    = cmd.sweep_rd | cmd.px_rd;
		ram_raddr = cmd.px_rd ? AW'(addr_q) : sweep_raddr;
	end

	// sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			wr_v_s3 <= 1'b0;
		end else begin
			v_s1    <= cmd.sweep_rd;
			v_s2    <= v_s1;
			wr_v_s3 <= v_s2 && (32'(a_s2) >= A_FIRST);
		end
	end

	// shift the read data into the two-row window; newest cell at tap zero
	always_ff @(posedge clk) begin
		a_s1 <= cnt_q;
		a_s2 <= a_s1;
		if (v_s1) begin
			sr_q[0] <= ram_rdata;
			for (int i = 1; i < SR_N; i++) begin
				sr_q[i] <= sr_q[i-1];
			end
		end
	end

	// eight-neighbour sum around the position a_s2 - FRAME_WIDTH - 1
	always_comb begin
		sum = (HW+3)'(sr_q[0]) + (HW+3)'(sr_q[1]) + (HW+3)'(sr_q[2])
		    + (HW+3)'(sr_q[FRAME_WIDTH]) + (HW+3)'(sr_q[FRAME_WIDTH+2])
		    + (HW+3)'(sr_q[2*FRAME_WIDTH]) + (HW+3)'(sr_q[2*FRAME_WIDTH+1])
		    + (HW+3)'(sr_q[2*FRAME_WIDTH+2]);
		avg       = sum[HW+2:3];
		hot       = (32'(a_s2) >= A_HOT);
		do_dec    = (sum[1:0] == 2'b00) && ((avg != '0) || hot);
		dec_val   = do_dec ? (avg - HW'(1)) : avg;
		// the two scratch corners outside the stencil always land as zero
		edge_zero = (32'(a_s2) == A_FIRST) || (32'(a_s2) == FS);
	end

	// register the write one row up
	always_ff @(posedge clk) begin
		wr_addr_s3 <= AW'(32'(a_s2) - A_FIRST);
		wr_data_s3 <= edge_zero ? '0 : dec_val;
	end

	// fold the request coordinates and form the frame address
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			row_q <= view_row;
			col_q <= view_col;
		end else begin
			if (cmd.row_sub) begin
				row_q <= row_q - ffe_pkg::ROW_W'(VIEW_ROWS);
			end
			if (cmd.col_sub) begin
				col_q <= col_q - ffe_pkg::COL_W'(FRAME_WIDTH);
			end
		end
		if (cmd.addr_load) begin
			addr_q <= AQ_W'((VIEW_FIRST_ROW + 32'(row_q)) * FRAME_WIDTH + 32'(col_q));
		end else if (cmd.addr_sub) begin
			addr_q <= addr_q - AQ_W'(FS);
		end
	end

	// base colour register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wen) begin
			base_q <= cfg_wdata;
		end
	end

	// map heat to a palette index, clamped to the top of the ramp
	always_comb begin
		lo     = {1'b0, ram_rdata[HW-1:1]} + base_q;
		top    = base_q + ffe_pkg::COLOUR_SPAN;
		colour = (lo > top) ? top : lo;
	end

	// hold the finished result
	always_ff @(posedge clk) begin
		if (cmd.res_pix) begin
			res_q <= {colour, colour};
		end else if (cmd.res_zero) begin
			res_q <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_d_q <= res_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;

	// status to the controller
	always_comb begin
		st.cnt_clear_last = (cnt_q == CNT_W'(FS - 1));
		st.cnt_end        = (cnt_q == CNT_W'(FS));
		st.pipe_busy      = v_s1 | v_s2 | wr_v_s3;
		st.row_ge         = (32'(row_q) >= VIEW_ROWS);
		st.col_ge         = (32'(col_q) >= FRAME_WIDTH);
		st.addr_ge        = (32'(addr_q) >= FS);
		st.out_free       = !out_v_q || m_tready;
	end

endmodule

// ----- hdl/ffe_ctrl.sv -----
// Controller of the fire effect frame engine: clearing pass, frame advance sweep and
// pixel read sequence. Depends on ffe_pkg.
module ffe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic          op_read,
	input  ffe_pkg::sts_t st,
	output ffe_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		CLEAR,
		IDLE,
		ADV_SWEEP,
		ADV_DRAIN,
		RD_ROW,
		RD_COL,
		RD_ADDR,
		RD_WAIT,
		RESULT
	} state_t;

	state_t state_q;
	logic   accept;

	assign s_tready = (state_q == IDLE);
	assign accept   = s_tvalid && s_tready;

	// decode commands from the state
	always_comb begin
		cmd = '0;
		case (state_q)
			CLEAR: begin
				cmd.clear_wr = 1'b1;
				cmd.cnt_inc  = 1'b1;
			end
			IDLE: begin
				cmd.cnt_clr = accept;
				cmd.load_in = accept;
			end
			ADV_SWEEP: begin
				cmd.sweep_rd = 1'b1;
				cmd.cnt_inc  = !st.cnt_end;
			end
			ADV_DRAIN: begin
				cmd.res_zero = !st.pipe_busy;
			end
			RD_ROW: begin
				cmd.row_sub = st.row_ge;
			end
			RD_COL: begin
				cmd.col_sub   = st.col_ge;
				cmd.addr_load = !st.col_ge;
			end
			RD_ADDR: begin
				cmd.addr_sub = st.addr_ge;
				cmd.px_rd    = !st.addr_ge;
			end
			RD_WAIT: begin
				cmd.res_pix = 1'b1;
			end
			RESULT: begin
				cmd.out_load = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
		end else begin
			case (state_q)
				CLEAR: begin
					if (st.cnt_clear_last) state_q <= IDLE;
				end
				IDLE: begin
					if (accept) state_q <= op_read ? RD_ROW : ADV_SWEEP;
				end
				ADV_SWEEP: begin
					if (st.cnt_end) state_q <= ADV_DRAIN;
				end
				ADV_DRAIN: begin
					if (!st.pipe_busy) state_q <= RESULT;
				end
				RD_ROW: begin
					if (!st.row_ge) state_q <= RD_COL;
				end
				RD_COL: begin
					if (!st.col_ge) state_q <= RD_ADDR;
				end
				RD_ADDR: begin
					if (!st.addr_ge) state_q <= RD_WAIT;
				end
				RD_WAIT: begin
					state_q <= RESULT;
				end
				RESULT: begin
					if (st.out_free) state_q <= IDLE;
				end
				default: begin
					state_q <= CLEAR;
				end
			endcase
		end
	end

endmodule

// ----- hdl/fire_effect_frame_engine.sv -----
// Top level of the fire effect frame engine; joins controller and datapath.
// Depends on ffe_pkg, ffe_ctrl, ffe_dpath (and ffe_ram through the datapath).

// The engine keeps a FRAME_ROWS x FRAME_WIDTH byte heat frame in one RAM and serves one
// request at a time. After reset it zeroes the RAM with s_tready low; configuration writes
// are taken during that time. An advance request (s_tuser = 0) streams the whole frame
// once through a two-row window, one cell per cycle through the single RAM read port,
// and writes each decayed cell one row up before it returns a result of zero. A read
// request (s_tuser = 1) folds row and column into range by repeated subtraction, reads
// one cell and returns the palette index in both bytes. A finished result waits in the
// output register while the next request is accepted.
module fire_effect_frame_engine #(
	parameter int FRAME_WIDTH    = ffe_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_ROWS     = ffe_pkg::FRAME_ROWS_DEF,
	parameter int HOT_ROW        = ffe_pkg::HOT_ROW_DEF,
	parameter int VIEW_FIRST_ROW = ffe_pkg::VIEW_FIRST_ROW_DEF,
	parameter int VIEW_ROWS      = ffe_pkg::VIEW_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [4:0] view_row, [13:5] view_col, [15:14] zero
	input  logic        s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] pixel_pair
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata
);

	ffe_pkg::cmd_t cmd;
	ffe_pkg::sts_t st;

	ffe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op_read  (s_tuser),
		.st       (st),
		.cmd      (cmd)
	);

	ffe_dpath #(
		.FRAME_WIDTH    (FRAME_WIDTH),
		.FRAME_ROWS     (FRAME_ROWS),
		.HOT_ROW        (HOT_ROW),
		.VIEW_FIRST_ROW (VIEW_FIRST_ROW),
		.VIEW_ROWS      (VIEW_ROWS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.view_row  (s_tdata[4:0]),
		.view_col  (s_tdata[13:5]),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- hdl/ffe_checker.sv -----
// Port-level checker for the fire effect frame engine, bound to the top level.
// Depends only on the top level's ports.
module ffe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	// repeat the colour index in both bytes
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:8] == m_tdata[7:0]))
		else $error("result bytes differ");

	// drop ready after each accepted request
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while one is in work");

	// raise a result only from a busy engine
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while engine idle");

endmodule

bind fire_effect_frame_engine ffe_checker u_ffe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/fire_effect_frame_engine_chk.sv -----
`timescale 1ns / 100ps
// Request types and the scoreboard for the fire effect frame engine testbench.
// Depends on ffe_pkg for the frame geometry and the colour ramp span.

package fire_tb_pkg;

	typedef enum logic {
		OP_ADVANCE = 1'b0,
		OP_READ    = 1'b1
	} fire_op_e;

	// request payload as packed into s_tdata, highest bits first
	typedef struct packed {
		logic [1:0] pad;
		logic [8:0] view_col;
		logic [4:0] view_row;
	} fire_req_t;

endpackage

module fire_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [4:0] view_row, [13:5] view_col, [15:14] zero
	input  logic        s_tuser,   // [0] operation
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [15:0] pixel_pair
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,
	output int          fail_count,
	output int          pixels_pending
);
	import fire_tb_pkg::*;

	localparam int WIDTH      = ffe_pkg::FRAME_WIDTH_DEF;
	localparam int ROWS       = ffe_pkg::FRAME_ROWS_DEF;
	localparam int HOT_START  = ffe_pkg::HOT_ROW_DEF * WIDTH;
	localparam int VIEW_FIRST = ffe_pkg::VIEW_FIRST_ROW_DEF;
	localparam int VIEW_COUNT = ffe_pkg::VIEW_ROWS_DEF;
	localparam int CELLS      = WIDTH * ROWS;

	// shadow copy of the block's frames and colour register
	bit   [7:0]  heat_map [0:CELLS-1];
	bit   [7:0]  cool_map [0:CELLS-1];
	logic [7:0]  base_colour;
	logic [15:0] expected_pixels [$];

	// smooth every inner cell into the scratch frame, then shift it up one row
	task automatic advance_heat();
		int sum;
		int avg;
		for (int p = WIDTH + 1; p < WIDTH + 1 + (ROWS - 2) * WIDTH - 2; p++) begin
			sum = heat_map[p-1] + heat_map[p+1]
			    + heat_map[p-WIDTH] + heat_map[p-WIDTH-1] + heat_map[p-WIDTH+1]
			    + heat_map[p+WIDTH] + heat_map[p+WIDTH-1] + heat_map[p+WIDTH+1];
			avg = sum >> 3;
			if ((sum % 4) == 0 && (avg != 0 || p >= HOT_START)) begin
				avg = avg - 1;
			end
			cool_map[p] = avg[7:0];
		end
		for (int i = 0; i < (ROWS - 2) * WIDTH; i++) begin
			heat_map[i] = cool_map[i+WIDTH];
		end
	endtask

	// map one display position to its palette index, doubled into both bytes
	function automatic logic [15:0] colour_of(fire_req_t req);
		int         row;
		int         col;
		int         addr;
		logic [7:0] idx;
		logic [7:0] ceiling;
		row     = req.view_row % VIEW_COUNT;
		col     = req.view_col % WIDTH;
		addr    = ((VIEW_FIRST + row) * WIDTH + col) % CELLS;
		idx     = (heat_map[addr] >> 1) + base_colour;
		ceiling = base_colour + ffe_pkg::COLOUR_SPAN;
		if (idx > ceiling) begin
			idx = ceiling;
		end
		return {idx, idx};
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [15:0] want;
		if (!arst_n) begin
			base_colour = 8'd0;
			fail_count     <= 0;
			pixels_pending <= 0;
		end else begin
			// compare a delivered result with the oldest request
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel_pair: unrequested result, expected none, actual %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (m_tdata !== want) begin
						$error("pixel_pair mismatch: expected %h, actual %h", want, m_tdata);
						fail_count <= fail_count + 1;
					end
				end
			end
			// predict the result of an accepted request
			if (s_tvalid && s_tready) begin
				if (fire_op_e'(s_tuser) == OP_READ) begin
					expected_pixels.push_back(colour_of(fire_req_t'(s_tdata)));
				end else begin
					advance_heat();
					expected_pixels.push_back(16'h0000);
				end
			end
			if (cfg_wen) begin
				base_colour = cfg_wdata;
			end
			pixels_pending <= expected_pixels.size();
		end
	end

endmodule

// ----- tb/fire_effect_frame_engine_tb.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for the fire effect frame engine.
// Depends on ffe_pkg, fire_tb_pkg and fire_frame_checker (fire_effect_frame_engine_chk.sv).

module fire_effect_frame_engine_tb;
	import fire_tb_pkg::*;

	localparam int CYCLE_LIMIT    = 2_500_000;
	localparam int MAX_ADVANCES   = 36;
	localparam int PHASE_ITEMS    = 16;
	localparam int PHASES         = 5;
	localparam int LONG_HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        cfg_wen;
	logic [7:0]  cfg_wdata;

	int fail_count;
	int pixels_pending;
	int cycle_cnt = 0;
	int advance_cnt;
	int read_cnt;
	int base_cnt;
	bit quiet;
	bit long_hold;

	fire_effect_frame_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	fire_frame_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.fail_count     (fail_count),
		.pixels_pending (pixels_pending)
	);

	always #10 clk = ~clk;

	// abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// offer one request, after an optional idle burst, and hold it until taken
	task automatic send_request(fire_op_e op, logic [4:0] row, logic [8:0] col);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, col, row};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_ADVANCE) begin
			advance_cnt++;
		end else begin
			read_cnt++;
		end
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pixels_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_base(logic [7:0] value);
		cfg_wdata <= value;
		cfg_wen   <= 1'b1;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		base_cnt++;
	endtask

	// random request, biased toward the lower display rows where the fire is
	task automatic send_random(int advance_pct);
		fire_op_e   op;
		logic [4:0] row;
		logic [8:0] col;
		op = ($urandom_range(0, 99) < advance_pct && advance_cnt < MAX_ADVANCES) ?
		     OP_ADVANCE : OP_READ;
		row = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(15, 24)) :
		                                   5'($urandom_range(0, 31));
		col = ($urandom_range(0, 9) < 8) ? 9'($urandom_range(0, 319)) :
		                                   9'($urandom_range(0, 511));
		send_request(op, row, col);
	endtask

	// output side: random stalls, plus one long hold-off on request
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold && !hold_done) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		logic [7:0] phase_base [0:PHASES-1];
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_wen   = 1'b0;
		cfg_wdata = '0;
		quiet     = 1'b0;
		long_hold = 1'b0;
		advance_cnt = 0;
		read_cnt    = 0;
		base_cnt    = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// cold frame at reset colour: corners of the field ranges and folding
		send_request(OP_READ, 5'd0, 9'd0);
		send_request(OP_READ, 5'd24, 9'd319);
		send_request(OP_READ, 5'd31, 9'd511);
		send_request(OP_READ, 5'd25, 9'd320);
		send_request(OP_ADVANCE, 5'd31, 9'd511);
		send_request(OP_ADVANCE, 5'd0, 9'd0);
		send_request(OP_READ, 5'd24, 9'd0);
		drain();

		// top base wraps the clamp limit below the base
		write_base(8'hFF);
		send_request(OP_READ, 5'd0, 9'd0);
		send_request(OP_READ, 5'd24, 9'd319);
		send_request(OP_ADVANCE, 5'd12, 9'd200);
		send_request(OP_READ, 5'd24, 9'd160);
		drain();

		// clamp limit lands exactly at the top of the palette
		write_base(8'hF0);
		send_request(OP_READ, 5'd31, 9'd0);
		send_request(OP_READ, 5'd0, 9'd511);
		send_request(OP_READ, 5'd12, 9'd100);
		drain();

		write_base(8'hF8);
		send_request(OP_READ, 5'd24, 9'd319);
		send_request(OP_READ, 5'd7, 9'd7);
		drain();

		// random phases, each under its own colour base
		phase_base[0] = 8'h00;
		phase_base[1] = 8'($urandom_range(0, 255));
		phase_base[2] = 8'hF9;
		phase_base[3] = 8'hFF;
		phase_base[4] = 8'($urandom_range(0, 255));
		for (int ph = 0; ph < PHASES; ph++) begin
			write_base(phase_base[ph]);
			if (ph == PHASES - 1) begin
				quiet = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// back up the output and keep reads coming so the input stalls
				if (ph == 2 && n == 5) begin
					long_hold = 1'b1;
					for (int k = 0; k < 6; k++) begin
						send_request(OP_READ, 5'($urandom_range(0, 31)),
						             9'($urandom_range(0, 511)));
					end
				end
				send_random(ph < 2 ? 50 : 20);
			end
			drain();
		end

		repeat (50) @(posedge clk);
		$display("Run covered %0d frame advances and %0d pixel reads under %0d colour bases,",
		         advance_cnt, read_cnt, base_cnt + 1);
		$display("with folded view coordinates, wrapped clamp limits and a long output stall.");
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- fire_effect_frame_engine.f -----
hdl/ffe_pkg.sv
hdl/ffe_ram.sv
hdl/ffe_dpath.sv
hdl/ffe_ctrl.sv
hdl/fire_effect_frame_engine.sv
hdl/ffe_checker.sv
tb/fire_effect_frame_engine_chk.sv
tb/fire_effect_frame_engine_tb.sv
